// ===== rtl/nsc_pkg.sv =====
package nsc_pkg;

    localparam int GRID      = 5;
    localparam int CELLS     = GRID * GRID;
    localparam int CELL_LAST = CELLS - 1;
    localparam int CENTER    = CELLS / 2;
    localparam int NUM_IMG   = 8;
    localparam int ROW_W     = 3;
    localparam int CNT_W     = 5;

    typedef logic [CELLS-1:0] t_img;
    typedef logic [NUM_IMG-1:0][CELLS-1:0] t_orbit;
    typedef logic [ROW_W-1:0] t_row_cnt;
    typedef logic [CNT_W-1:0] t_cnt;

    // New cell (x, y) takes old cell (4 - y, x); cell i sits in bit 24 - i.
    function automatic t_img rotate_ccw(input t_img w);
        t_img r;
        r = '0;
        for (int y = 0; y < GRID; y++) begin
            for (int x = 0; x < GRID; x++) begin
                r[CELL_LAST - (x + GRID * y)] = w[CELL_LAST - ((GRID - 1 - y) + GRID * x)];
            end
        end
        return r;
    endfunction

    // New cell (x, y) takes old cell (4 - x, y).
    function automatic t_img mirror_h(input t_img w);
        t_img r;
        r = '0;
        for (int y = 0; y < GRID; y++) begin
            for (int x = 0; x < GRID; x++) begin
                r[CELL_LAST - (x + GRID * y)] = w[CELL_LAST - ((GRID - 1 - x) + GRID * y)];
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/nsc_orbit.sv =====
module nsc_orbit
    import nsc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_img   i_cells,
    output logic   o_valid,
    output t_orbit o_img
);

    logic   r_valid;
    t_orbit r_img;
    t_orbit n_img;

    // All eight images are pure wiring; one register stage holds them.
    always_comb begin
        n_img[0] = i_cells;
        n_img[1] = rotate_ccw(i_cells);
        n_img[2] = rotate_ccw(rotate_ccw(i_cells));
        n_img[3] = rotate_ccw(rotate_ccw(rotate_ccw(i_cells)));
        n_img[4] = mirror_h(i_cells);
        n_img[5] = rotate_ccw(mirror_h(i_cells));
        n_img[6] = rotate_ccw(rotate_ccw(mirror_h(i_cells)));
        n_img[7] = rotate_ccw(rotate_ccw(rotate_ccw(mirror_h(i_cells))));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_img <= n_img;
    end

    assign o_valid = r_valid;
    assign o_img   = r_img;

endmodule

// ===== rtl/nsc_min.sv =====
module nsc_min
    import nsc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_orbit i_img,
    output logic   o_valid,
    output t_orbit o_img,
    output t_img   o_min
);

    logic       r_v1, r_v2, r_v3;
    t_img [3:0] r_min1;
    t_img [1:0] r_min2;
    t_img       r_min3;
    t_orbit     r_img1, r_img2, r_img3;
    t_img [3:0] n_min1;
    t_img [1:0] n_min2;
    t_img       n_min3;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_min1[k] = (i_img[2*k+1] < i_img[2*k]) ? i_img[2*k+1] : i_img[2*k];
        end
        for (int k = 0; k < 2; k++) begin
            n_min2[k] = (r_min1[2*k+1] < r_min1[2*k]) ? r_min1[2*k+1] : r_min1[2*k];
        end
        n_min3 = (r_min2[1] < r_min2[0]) ? r_min2[1] : r_min2[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_min1 <= n_min1;
        r_min2 <= n_min2;
        r_min3 <= n_min3;
        r_img1 <= i_img;
        r_img2 <= r_img1;
        r_img3 <= r_img2;
    end

    assign o_valid = r_v3;
    assign o_img   = r_img3;
    assign o_min   = r_min3;

endmodule

// ===== rtl/nsc_count.sv =====
module nsc_count
    import nsc_pkg::*;
(
    input  logic i_clk,
    input  t_img i_cells,
    output t_cnt o_outer,
    output t_cnt o_total
);

    t_row_cnt [GRID-1:0] r_row;
    t_row_cnt [GRID-1:0] n_row;
    logic                r_ctr1, r_ctr2;
    t_cnt                r_total2, r_total3, r_total4;
    t_cnt                r_outer3, r_outer4;
    t_cnt                n_total;

    always_comb begin
        for (int y = 0; y < GRID; y++) begin
            n_row[y] = '0;
            for (int x = 0; x < GRID; x++) begin
                n_row[y] = n_row[y] + t_row_cnt'(i_cells[y * GRID + x]);
            end
        end
        n_total = '0;
        for (int y = 0; y < GRID; y++) begin
            n_total = n_total + t_cnt'(r_row[y]);
        end
    end

    // Four stages to line up with the image and minimum path.
    always_ff @(posedge i_clk) begin
        r_row    <= n_row;
        r_ctr1   <= i_cells[CENTER];
        r_total2 <= n_total;
        r_ctr2   <= r_ctr1;
        r_total3 <= r_total2;
        r_outer3 <= r_total2 - t_cnt'(r_ctr2);
        r_total4 <= r_total3;
        r_outer4 <= r_outer3;
    end

    assign o_outer = r_outer4;
    assign o_total = r_total4;

endmodule

// ===== rtl/neighborhood_symmetry_canonicalizer_top.sv =====
// A neighborhood accepted with start passes the orbit register and the minimum
// tree before o_done strobes. Throughput: one neighborhood per cycle; busy is
// never raised, since each of the four pipeline stages passes data on every clock.
// Reset (synchronous, active low) clears only the stage valid bits; payload
// registers are left as they are. The receiver cannot stall the pipeline.
module neighborhood_symmetry_canonicalizer_top
    import nsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [24:0] i_neighborhood,
    output logic        o_done,
    output logic [24:0] o_orbit_0,
    output logic [24:0] o_orbit_1,
    output logic [24:0] o_orbit_2,
    output logic [24:0] o_orbit_3,
    output logic [24:0] o_orbit_4,
    output logic [24:0] o_orbit_5,
    output logic [24:0] o_orbit_6,
    output logic [24:0] o_orbit_7,
    output logic [24:0] o_canonical_value,
    output logic [4:0]  o_outer_count,
    output logic [4:0]  o_total_count
);

    logic   s1_valid;
    t_orbit s1_img;
    t_orbit out_img;

    // The pipeline never holds, so every start is a transfer.
    assign busy = 1'b0;

    // Stage 1: the eight dihedral images, formed by wiring and registered.
    nsc_orbit u_orbit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_cells (i_neighborhood),
        .o_valid (s1_valid),
        .o_img   (s1_img)
    );

    // Stages 2 to 4: a registered tree of compares picks the smallest image,
    // while the images ride along beside it.
    nsc_min u_min (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_img   (s1_img),
        .o_valid (o_done),
        .o_img   (out_img),
        .o_min   (o_canonical_value)
    );

    // Live-cell counts run in a parallel path of the same depth.
    nsc_count u_count (
        .i_clk   (i_clk),
        .i_cells (i_neighborhood),
        .o_outer (o_outer_count),
        .o_total (o_total_count)
    );

    assign o_orbit_0 = out_img[0];
    assign o_orbit_1 = out_img[1];
    assign o_orbit_2 = out_img[2];
    assign o_orbit_3 = out_img[3];
    assign o_orbit_4 = out_img[4];
    assign o_orbit_5 = out_img[5];
    assign o_orbit_6 = out_img[6];
    assign o_orbit_7 = out_img[7];

    // Every accepted transfer comes out as a result strobe on o_done.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##4 o_done)
        else $error("result strobe missing four cycles after start");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, 4))
        else $error("result strobe without a matching start");

    // The canonical value is no larger than any image and equals one of them.
    a_min_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_canonical_value <= o_orbit_0) && (o_canonical_value <= o_orbit_1)
                && (o_canonical_value <= o_orbit_2) && (o_canonical_value <= o_orbit_3)
                && (o_canonical_value <= o_orbit_4) && (o_canonical_value <= o_orbit_5)
                && (o_canonical_value <= o_orbit_6) && (o_canonical_value <= o_orbit_7))
        else $error("canonical value exceeds an image");

    a_min_member: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_canonical_value == o_orbit_0) || (o_canonical_value == o_orbit_1)
                || (o_canonical_value == o_orbit_2) || (o_canonical_value == o_orbit_3)
                || (o_canonical_value == o_orbit_4) || (o_canonical_value == o_orbit_5)
                || (o_canonical_value == o_orbit_6) || (o_canonical_value == o_orbit_7))
        else $error("canonical value is not one of the images");

    // The two counts differ by the centre cell of the original image.
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_total_count - o_outer_count) == {4'b0000, o_orbit_0[CENTER]})
        else $error("outer and total counts disagree on the centre cell");

endmodule
